// ----- rtl/kwm_pkg.sv -----
// Package for the k-way sorted merge: status codes, commands and shared types.
// No dependencies.
package kwm_pkg;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ID_W  = 3;

  typedef struct packed {
    logic             found;
    logic [5:0]       idx;
  } kwm_sel_t;
endpackage

// ----- rtl/k_way_sorted_merge_top.sv -----
// K-way sorted merge: per-list FIFOs in one memory, head registers, minimum select.
// Each accepted word's result is registered and valid in the cycle after acceptance.
// A push is handled in S_IDLE alone; a pop passes S_IDLE (select and read), then S_LOAD
// (head reload), which stalls the input; a held result word stalls the input until it leaves.
// rst_n synchronous active low clears pointers, counts and head valid bits; memory
// contents stay undefined and need no clearing pass. Depends on kwm_pkg, kwm_store, kwm_select.
module k_way_sorted_merge_top
  import kwm_pkg::*;
#(
  parameter int unsigned LISTS      = 8,
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [ID_W-1:0]         in_list_id,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_out_value,
  output logic [ID_W-1:0]         out_source_list
);
  localparam int unsigned LW = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int unsigned PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = LW + PW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0]           rpos_r [LISTS];
  logic [CW-1:0]           fill_r [LISTS];
  logic [LISTS-1:0]        hvalid_r;
  logic signed [VAL_W-1:0] hvalue_r [LISTS];
  logic [LW-1:0]           ld_idx_r;
  logic                    ovalid_r;
  logic [1:0]              ostat_r;
  logic signed [VAL_W-1:0] oval_r;
  logic [ID_W-1:0]         osrc_r;

  kwm_sel_t         sel;
  logic [LW-1:0]    sidx;
  logic [LW-1:0]    pid;
  logic             id_ok;
  logic             full;
  logic             acc;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [PW-1:0]    wpos;
  logic [PW:0]      wsum;
  logic [PW-1:0]    rnext;
  logic [VAL_W-1:0] rdata;

  kwm_select #(.LISTS(LISTS), .LW(LW)) u_sel (
    .hvalid(hvalid_r), .hvalue(hvalue_r), .sel(sel)
  );

  assign sidx  = sel.idx[LW-1:0];
  assign pid   = LW'(in_list_id);
  assign id_ok = (32'(in_list_id) < LISTS);
  assign full  = !id_ok || (32'(fill_r[pid]) >= LIST_DEPTH);
  assign in_stall = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign acc   = in_valid && !in_stall;
  assign we    = acc && (in_command == CMD_PUSH) && !full;
  assign wsum  = (PW+1)'(rpos_r[pid]) + (PW+1)'(fill_r[pid]);
  assign wpos  = (32'(wsum) >= LIST_DEPTH) ? PW'(32'(wsum) - LIST_DEPTH) : PW'(wsum);
  assign waddr = {pid, wpos};
  assign rnext = (32'(rpos_r[sidx]) + 1 >= LIST_DEPTH) ? '0 : PW'(rpos_r[sidx] + 1'b1);
  assign raddr = {sidx, rnext};

  kwm_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_value), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc && in_command == CMD_POP && sel.found) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hvalid_r <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        rpos_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD && fill_r[ld_idx_r] != '0) begin
        hvalue_r[ld_idx_r] <= rdata;
      end
      if (acc) begin
        ovalid_r <= 1'b1;
        if (in_command == CMD_PUSH) begin
          oval_r <= '0;
          osrc_r <= '0;
          if (full) begin
            ostat_r <= ST_FULL;
          end else begin
            ostat_r     <= ST_OK;
            fill_r[pid] <= fill_r[pid] + 1'b1;
            if (!hvalid_r[pid]) begin
              hvalid_r[pid] <= 1'b1;
              hvalue_r[pid] <= in_value;
            end
          end
        end else if (!sel.found) begin
          ostat_r <= ST_EMPTY;
          oval_r  <= '0;
          osrc_r  <= '0;
        end else begin
          ostat_r        <= ST_OK;
          oval_r         <= hvalue_r[sidx];
          osrc_r         <= ID_W'(sidx);
          ld_idx_r       <= sidx;
          rpos_r[sidx]   <= rnext;
          fill_r[sidx]   <= fill_r[sidx] - 1'b1;
          if (fill_r[sidx] == CW'(1)) hvalid_r[sidx] <= 1'b0;
        end
      end else if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ostat_r;
  assign out_out_value   = oval_r;
  assign out_source_list = osrc_r;
endmodule

// ----- rtl/kwm_store.sv -----
// Element store for all list FIFOs: one write port, one registered read port.
// Depends on kwm_pkg.
module kwm_store
  import kwm_pkg::*;
#(
  parameter int unsigned AW = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);
  logic [VAL_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/kwm_select.sv -----
// Minimum search over list heads, lowest index wins ties, signed compare.
// Depends on kwm_pkg.
module kwm_select
  import kwm_pkg::*;
#(
  parameter int unsigned LISTS = 8,
  parameter int unsigned LW    = 3
) (
  input  logic [LISTS-1:0]            hvalid,
  input  logic signed [VAL_W-1:0]     hvalue [LISTS],
  output kwm_sel_t                    sel
);
  logic              found;
  logic [LW-1:0]     best;
  logic signed [VAL_W-1:0] bv;

  always_comb begin
    found = 1'b0;
    best  = '0;
    bv    = '0;
    for (int i = 0; i < LISTS; i++) begin
      if (hvalid[i] && (!found || hvalue[i] < bv)) begin
        found = 1'b1;
        best  = LW'(i);
        bv    = hvalue[i];
      end
    end
    sel.found = found;
    sel.idx   = 6'(best);
  end
endmodule

// ----- rtl/kwm_checker.sv -----
// Port-level checks for the k-way merge top level, with its bind.
// Depends on kwm_pkg and k_way_sorted_merge_top.
module kwm_checker
  import kwm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [VAL_W-1:0]  out_out_value,
  input logic [ID_W-1:0]   out_source_list
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_out_value))
    else $error("stalled word changed");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY))
    else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_out_value == '0 && out_source_list == '0)
    else $error("error word carries data");
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word gave no result");
endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_out_value(out_out_value), .out_source_list(out_source_list)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for k_way_sorted_merge_top: pushes and pops with random idling,
// results compared against a behavioural merge model held here.
// Depends on kwm_pkg and k_way_sorted_merge_top.
module tb_top;
  import kwm_pkg::*;

  localparam int unsigned NLISTS = 8;
  localparam int unsigned DEPTH  = 256;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
    logic [ID_W-1:0]         source;
  } merge_word_t;

  typedef struct packed {
    logic                    cmd;
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    merge_word_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_PUSH;
  logic [ID_W-1:0] in_list_id = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [VAL_W-1:0] out_out_value;
  logic [ID_W-1:0] out_source_list;

  logic signed [VAL_W-1:0] list_fifo [NLISTS][$];
  merge_word_t pending_words [$];
  int mismatches = 0;
  bit calm = 1'b0;
  int send_done = 0;

  always #1 clk = ~clk;

  k_way_sorted_merge_top #(.LISTS(NLISTS), .LIST_DEPTH(DEPTH)) dut (.*);

  function automatic merge_word_t merge_step(logic cmd, logic [ID_W-1:0] id,
                                             logic signed [VAL_W-1:0] v);
    merge_word_t w;
    int best;
    w = '0;
    best = -1;
    if (cmd == CMD_PUSH) begin
      if (list_fifo[id].size() >= DEPTH) w.status = ST_FULL;
      else list_fifo[id].insert(list_fifo[id].size(), v);
    end else begin
      for (int i = 0; i < NLISTS; i++)
        if (list_fifo[i].size() > 0 &&
            (best < 0 || list_fifo[i][0] < list_fifo[best][0])) best = i;
      if (best < 0) w.status = ST_EMPTY;
      else begin
        w.value = list_fifo[best].pop_front();
        w.source = best[ID_W-1:0];
      end
    end
    return w;
  endfunction

  task automatic send_word(logic cmd, logic [ID_W-1:0] id, logic signed [VAL_W-1:0] v,
                           bit typed, merge_word_t want);
    merge_word_t w;
    bit idle;
    idle = 1'b0;
    while (!calm && $urandom_range(99) < 30) begin
      if (!idle) in_valid <= 1'b0;
      idle = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_list_id <= id;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    w = merge_step(cmd, id, v);
    if (typed && w != want) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with model: %h vs %h", want, w);
    end
    pending_words.insert(pending_words.size(), w);
  endtask

  always @(posedge clk) begin
    merge_word_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %0d %0d %0d",
                                         out_status, out_out_value, out_source_list);
        end else begin
          w = pending_words.pop_front();
          if (out_status !== w.status || out_out_value !== w.value ||
              out_source_list !== w.source) begin
            mismatches++;
            if (mismatches <= 10)
              $display("exp %0d %0d %0d got %0d %0d %0d", w.status, w.value, w.source,
                       out_status, out_out_value, out_source_list);
          end
        end
      end
      out_stall <= (!calm && $urandom_range(99) < 30);
    end
  end

  initial begin
    stim_row_t rows [$];
    merge_word_t z;
    int n;
    z = '0;
    rows.insert(rows.size(), '{CMD_POP, 3'd0, 32'sd0, 1'b1, '{ST_EMPTY, 32'sd0, 3'd0}});
    rows.insert(rows.size(), '{CMD_PUSH, 3'd7, 32'h7fffffff, 1'b1, z});
    rows.insert(rows.size(), '{CMD_PUSH, 3'd0, 32'h80000000, 1'b1, z});
    rows.insert(rows.size(), '{CMD_PUSH, 3'd3, 32'sd5, 1'b1, z});
    rows.insert(rows.size(), '{CMD_PUSH, 3'd5, 32'sd5, 1'b1, z});
    rows.insert(rows.size(), '{CMD_PUSH, 3'd0, -32'sd1, 1'b1, z});
    rows.insert(rows.size(), '{CMD_POP, 3'd6, 32'hffffffff, 1'b1,
                               '{ST_OK, 32'h80000000, 3'd0}});
    rows.insert(rows.size(), '{CMD_POP, 3'd0, 32'sd0, 1'b1, '{ST_OK, -32'sd1, 3'd0}});
    rows.insert(rows.size(), '{CMD_POP, 3'd0, 32'sd0, 1'b1, '{ST_OK, 32'sd5, 3'd3}});
    rows.insert(rows.size(), '{CMD_POP, 3'd0, 32'sd0, 1'b0, z});
    rows.insert(rows.size(), '{CMD_POP, 3'd0, 32'sd0, 1'b0, z});
    rows.insert(rows.size(), '{CMD_POP, 3'd0, 32'sd0, 1'b1, '{ST_EMPTY, 32'sd0, 3'd0}});
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].id, rows[i].value, rows[i].typed,
                                rows[i].want);
    // fill list 2 to the brim, overflow it, then drain everything
    for (int i = 0; i < DEPTH + 2; i++) send_word(CMD_PUSH, 3'd2, $urandom, 1'b0, z);
    while (send_done < 2 * DEPTH) begin
      send_word(CMD_POP, 3'd0, 32'sd0, 1'b0, z);
      send_done++;
    end
    n = 0;
    while (n < 1170) begin
      calm = (n >= 800 && n < 1000);
      if ($urandom_range(99) < 55)
        send_word(CMD_PUSH, ID_W'($urandom_range(7)), ($urandom_range(3) == 0) ?
                  VAL_W'($signed($urandom_range(3) - 2)) : VAL_W'($urandom), 1'b0, z);
      else send_word(CMD_POP, ID_W'($urandom), VAL_W'($urandom), 1'b0, z);
      n++;
    end
    in_valid <= 1'b0;
    calm = 1'b1;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
